// File: sv/rgbhsv_pkg.sv
// Shared widths, constants and types of the RGB to HSV converter.
package rgbhsv_pkg;

    localparam int COLOR_W = 24;
    localparam int CH_W    = 8;
    localparam int HUE_W   = 9;
    localparam int SAT_W   = 16;

    // hue numerator is at most 841 * 255, the divisor 2 * d at most 510
    localparam int HNUM_W  = 18;
    localparam int HDEN_W  = 9;
    localparam int SNUM_W  = CH_W + SAT_W;

    // per-sector offsets: 360.5, 120.5 and 240.5 degrees, doubled
    localparam logic [9:0] HUE_OFS_RED   = 10'd721;
    localparam logic [9:0] HUE_OFS_GREEN = 10'd241;
    localparam logic [9:0] HUE_OFS_BLUE  = 10'd481;
    localparam logic [6:0] HUE_SCALE     = 7'd120;
    localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;

    // which component holds the maximum; red wins ties, then green
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

endpackage

// File: sv/rgbhsv_pix_if.sv
// Input channel: one packed RGB pixel per beat.
interface rgbhsv_pix_if;
    logic                          valid;
    logic                          ready;
    logic [rgbhsv_pkg::COLOR_W-1:0] color_word;

    modport source (output valid, output color_word, input ready);
    modport sink   (input valid, input color_word, output ready);
endinterface

// File: sv/rgbhsv_hsv_if.sv
// Output channel: hue, saturation and value per beat.
interface rgbhsv_hsv_if;
    logic                         valid;
    logic                         ready;
    logic [rgbhsv_pkg::HUE_W-1:0] hue_degrees;
    logic [rgbhsv_pkg::SAT_W-1:0] saturation_q16;
    logic [rgbhsv_pkg::CH_W-1:0]  brightness;

    modport source (output valid, output hue_degrees, output saturation_q16,
                    output brightness, input ready);
    modport sink   (input valid, input hue_degrees, input saturation_q16,
                    input brightness, output ready);
endinterface

// File: sv/rgb_to_hsv_converter.sv
// Top level of the streaming RGB to HSV pixel converter.
// Converts one packed 24-bit RGB pixel (red in the high byte) per beat into
// hue in whole degrees (0..359), saturation scaled by 65535 (truncated) and
// value (the largest component). Throughput is one pixel per clock while
// the output is not stalled. In the pipeline, one stage
// finds max/min, one forms the numerators, 17 stages run the two restoring
// dividers (load plus one quotient bit per stage, 16 bits for saturation,
// hue uses the same depth), and one stage wraps the hue and forms the output
// register. Gray pixels give hue 0, black pixels give saturation 0. The whole
// pipeline advances together whenever the output register is empty or is
// being taken. While a finished result waits untaken, everything holds,
// the input included, so a stall neither drops nor repeats a beat.
module rgb_to_hsv_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    rgbhsv_pix_if.sink           pix,
    rgbhsv_hsv_if.source         hsv
);

    localparam int CW = rgbhsv_pkg::CH_W;

    // global pipeline advance
    logic en;
    logic ovld_reg;

    assign en        = !ovld_reg || hsv.ready;
    assign pix.ready = en;

    // ---------------- stage 1: unpack, max/min, sector ----------------
    logic [CW-1:0] r_in, g_in, b_in;
    logic [CW-1:0] mx_next, mn_next;
    rgbhsv_pkg::max_sel_t sel_next;

    assign r_in = pix.color_word[3*CW-1:2*CW];
    assign g_in = pix.color_word[2*CW-1:CW];
    assign b_in = pix.color_word[CW-1:0];

    always_comb
    begin
        priority if (r_in >= g_in && r_in >= b_in)
        begin
            sel_next = rgbhsv_pkg::SEL_RED;
            mx_next  = r_in;
        end
        else if (g_in >= b_in)
        begin
            sel_next = rgbhsv_pkg::SEL_GREEN;
            mx_next  = g_in;
        end
        else
        begin
            sel_next = rgbhsv_pkg::SEL_BLUE;
            mx_next  = b_in;
        end
        mn_next = (r_in < g_in) ? r_in : g_in;
        mn_next = (mn_next < b_in) ? mn_next : b_in;
    end

    logic                 s1_vld_reg;
    logic [CW-1:0]        s1_r_reg, s1_g_reg, s1_b_reg, s1_mx_reg, s1_d_reg;
    rgbhsv_pkg::max_sel_t s1_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg   <= r_in;
            s1_g_reg   <= g_in;
            s1_b_reg   <= b_in;
            s1_mx_reg  <= mx_next;
            s1_d_reg   <= mx_next - mn_next;
            s1_sel_reg <= sel_next;
        end
    end

    // ---------------- stage 2: numerators and divisors ----------------
    logic [CW:0]          cdiff;     // two's complement difference, 9 bits
    logic [9:0]           hofs;
    logic signed [19:0]   hnum_s;
    logic [19:0]          ofs_prod;
    logic [rgbhsv_pkg::HNUM_W-1:0] hnum_next;
    logic [rgbhsv_pkg::SNUM_W-1:0] snum_next;

    always_comb
    begin
        unique case (s1_sel_reg)
            rgbhsv_pkg::SEL_RED:
            begin
                cdiff = {1'b0, s1_g_reg} - {1'b0, s1_b_reg};
                hofs  = rgbhsv_pkg::HUE_OFS_RED;
            end
            rgbhsv_pkg::SEL_GREEN:
            begin
                cdiff = {1'b0, s1_b_reg} - {1'b0, s1_r_reg};
                hofs  = rgbhsv_pkg::HUE_OFS_GREEN;
            end
            rgbhsv_pkg::SEL_BLUE:
            begin
                cdiff = {1'b0, s1_r_reg} - {1'b0, s1_g_reg};
                hofs  = rgbhsv_pkg::HUE_OFS_BLUE;
            end
            default:
            begin
                cdiff = '0;
                hofs  = rgbhsv_pkg::HUE_OFS_RED;
            end
        endcase
        ofs_prod  = 20'(hofs) * 20'(s1_d_reg);
        hnum_s    = 20'($signed(cdiff)) * $signed(20'(rgbhsv_pkg::HUE_SCALE))
                    + $signed(ofs_prod);
        // always positive, fits 18 bits
        hnum_next = hnum_s[rgbhsv_pkg::HNUM_W-1:0];
        // d * 65535
        snum_next = {s1_d_reg, 16'd0} - rgbhsv_pkg::SNUM_W'(s1_d_reg);
    end

    logic                          s2_vld_reg;
    logic [rgbhsv_pkg::HNUM_W-1:0] s2_hnum_reg;
    logic [rgbhsv_pkg::HDEN_W-1:0] s2_hden_reg;
    logic [rgbhsv_pkg::SNUM_W-1:0] s2_snum_reg;
    logic [CW-1:0]                 s2_mx_reg;
    logic                          s2_gray_reg;
    logic                          s2_black_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_hnum_reg  <= hnum_next;
            s2_hden_reg  <= {s1_d_reg, 1'b0};
            s2_snum_reg  <= snum_next;
            s2_mx_reg    <= s1_mx_reg;
            s2_gray_reg  <= (s1_d_reg == '0);
            s2_black_reg <= (s1_mx_reg == '0);
        end
    end

    // ---------------- dividers ----------------
    // hue: (numerator) / (2d); quotient lands in 60..420
    logic                          hdiv_vld;
    logic [rgbhsv_pkg::SAT_W-1:0]  hdiv_quo;
    logic [CW:0]                   hdiv_side;   // {gray, max}
    logic                          sdiv_vld;
    logic [rgbhsv_pkg::SAT_W-1:0]  sdiv_quo;
    logic                          sdiv_side;   // black

    rgbhsv_div #(
        .DEN_W  (rgbhsv_pkg::HDEN_W),
        .QUO_W  (rgbhsv_pkg::SAT_W),
        .SIDE_W (CW + 1)
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .num       ((rgbhsv_pkg::HDEN_W + rgbhsv_pkg::SAT_W)'(s2_hnum_reg)),
        .den       (s2_hden_reg),
        .side      ({s2_gray_reg, s2_mx_reg}),
        .out_valid (hdiv_vld),
        .quo       (hdiv_quo),
        .out_side  (hdiv_side)
    );

    rgbhsv_div #(
        .DEN_W  (CW),
        .QUO_W  (rgbhsv_pkg::SAT_W),
        .SIDE_W (1)
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .num       (s2_snum_reg),
        .den       (s2_mx_reg),
        .side      (s2_black_reg),
        .out_valid (sdiv_vld),
        .quo       (sdiv_quo),
        .out_side  (sdiv_side)
    );

    // ---------------- output stage: hue wrap and masking ----------------
    logic [rgbhsv_pkg::HUE_W-1:0] hq;
    logic [rgbhsv_pkg::HUE_W-1:0] hue_next;
    logic [rgbhsv_pkg::SAT_W-1:0] sat_next;

    always_comb
    begin
        hq = hdiv_quo[rgbhsv_pkg::HUE_W-1:0];
        if (hdiv_side[CW])
        begin
            hue_next = '0;
        end
        else if (hq >= rgbhsv_pkg::HUE_WRAP)
        begin
            hue_next = hq - rgbhsv_pkg::HUE_WRAP;
        end
        else
        begin
            hue_next = hq;
        end
        sat_next = sdiv_side ? '0 : sdiv_quo;
    end

    logic [rgbhsv_pkg::HUE_W-1:0] hue_reg;
    logic [rgbhsv_pkg::SAT_W-1:0] sat_reg;
    logic [CW-1:0]                bright_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            ovld_reg <= hdiv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= hdiv_side[CW-1:0];
        end
    end

    assign hsv.valid          = ovld_reg;
    assign hsv.hue_degrees    = hue_reg;
    assign hsv.saturation_q16 = sat_reg;
    assign hsv.brightness     = bright_reg;

    // ---------------- assertions ----------------
    // the two divider pipelines must stay in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        hdiv_vld == sdiv_vld)
        else $error("hue and saturation divider valids diverged");

    // hue wrap must leave a value below a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid |-> (hsv.hue_degrees < rgbhsv_pkg::HUE_WRAP))
        else $error("hue out of range");

    // a black pixel has zero hue and zero saturation
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv.valid && hsv.brightness == '0)
            |-> (hsv.saturation_q16 == '0 && hsv.hue_degrees == '0))
        else $error("black pixel with nonzero hue or saturation");

    // a beat taken at the output advances the pipeline in the same cycle
    a_take_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv.valid && hsv.ready && !hdiv_vld) |=> !hsv.valid)
        else $error("output beat repeated after being taken");

endmodule

// File: sv/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module rgbhsv_div #(
    parameter int DEN_W  = 8,
    parameter int QUO_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [DEN_W+QUO_W-1:0]   num,
    input  logic [DEN_W-1:0]         den,
    input  logic [SIDE_W-1:0]        side,
    output logic                     out_valid,
    output logic [QUO_W-1:0]         quo,
    output logic [SIDE_W-1:0]        out_side
);

    // stage k holds the partial remainder after k quotient bits; ql holds
    // the numerator bits still to shift in, with quotient bits filling in
    // from the bottom. Requires num < den * 2**QUO_W.
    logic [QUO_W:0]        vld_reg;
    logic [DEN_W-1:0]      rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]      ql_reg   [QUO_W+1];
    logic [DEN_W-1:0]      den_reg  [QUO_W+1];
    logic [SIDE_W-1:0]     side_reg [QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QUO_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num[DEN_W+QUO_W-1:QUO_W];
            ql_reg[0]   <= num[QUO_W-1:0];
            den_reg[0]  <= den;
            side_reg[0] <= side;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] ql_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], ql_reg[k-1][QUO_W-1]};
            ge       = (trial >= {1'b0, den_reg[k-1]});
            diff     = trial - {1'b0, den_reg[k-1]};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            ql_next  = {ql_reg[k-1][QUO_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                ql_reg[k]   <= ql_next;
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign quo       = ql_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

// File: test/tb_rgb_to_hsv_converter.sv
// Self-checking testbench of the streaming RGB to HSV pixel converter.
module tb_rgb_to_hsv_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLOR_W = rgbhsv_pkg::COLOR_W;
    localparam int CH_W    = rgbhsv_pkg::CH_W;
    localparam int HUE_W   = rgbhsv_pkg::HUE_W;
    localparam int SAT_W   = rgbhsv_pkg::SAT_W;

    // Converted pixel, one field per output of the block.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [CH_W-1:0]  val;
    } hsv_triple_t;

    // Keeps the converted pixels still owed by the block, oldest first.
    // The conversion is stateless, so every prediction stands on its own.
    class hsv_scoreboard;
        hsv_triple_t owed_hsv[$];
        int unsigned mismatches;

        // Exact integer hue/saturation/value of one packed pixel.
        function hsv_triple_t predict_hsv(logic [COLOR_W-1:0] word);
            int                   r, g, b;
            int                   top, bottom, spread, numer;
            rgbhsv_pkg::max_sel_t sel;
            hsv_triple_t          res;
            r = int'(word[23:16]);
            g = int'(word[15:8]);
            b = int'(word[7:0]);
            // red wins a tie for the maximum, then green
            if (r >= g && r >= b)
                sel = rgbhsv_pkg::SEL_RED;
            else if (g >= b)
                sel = rgbhsv_pkg::SEL_GREEN;
            else
                sel = rgbhsv_pkg::SEL_BLUE;
            case (sel)
                rgbhsv_pkg::SEL_RED:   top = r;
                rgbhsv_pkg::SEL_GREEN: top = g;
                default:               top = b;
            endcase
            bottom = (r < g) ? r : g;
            bottom = (bottom < b) ? bottom : b;
            spread = top - bottom;
            // doubled sector offsets keep the half-degree rounding in integers
            case (sel)
                rgbhsv_pkg::SEL_RED:   numer = 120 * (g - b) + 721 * spread;
                rgbhsv_pkg::SEL_GREEN: numer = 120 * (b - r) + 241 * spread;
                default:               numer = 120 * (r - g) + 481 * spread;
            endcase
            res.hue = (spread == 0) ? '0 : HUE_W'((numer / (2 * spread)) % 360);
            res.sat = (top == 0) ? '0 : SAT_W'((spread * 65535) / top);
            res.val = CH_W'(top);
            return res;
        endfunction

        function void note_pixel(logic [COLOR_W-1:0] word);
            owed_hsv.push_back(predict_hsv(word));
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
        endfunction

        function void check_result(hsv_triple_t got);
            hsv_triple_t want;
            if (owed_hsv.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, got.hue, got.sat, got.val);
                return;
            end
            want = owed_hsv.pop_front();
            if (got.hue !== want.hue)
                flag("hue", 32'(want.hue), 32'(got.hue));
            if (got.sat !== want.sat)
                flag("saturation", 32'(want.sat), 32'(got.sat));
            if (got.val !== want.val)
                flag("value", 32'(want.val), 32'(got.val));
        endfunction

        function int unsigned pending();
            return owed_hsv.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rgbhsv_pix_if pix_ch();
    rgbhsv_hsv_if hsv_ch();

    rgb_to_hsv_converter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch.sink),
        .hsv   (hsv_ch.source)
    );

    hsv_scoreboard sb = new;

    // no_idle: final stretch runs both sides at full rate.
    // long_hold_pending: asks the output side for one long back-pressure stretch.
    bit no_idle;
    bit long_hold_pending;

    localparam int LONG_HOLD   = 120;  // well beyond the 20-deep pipeline
    localparam int DRAIN_WAIT  = 40;   // extra idle wait after the final drain

    // Corner pixels: black, white, primaries, every two-way tie for the
    // maximum, gray, smallest nonzero spreads and hues next to the 0/360 wrap.
    localparam logic [COLOR_W-1:0] CORNER_PIXELS [21] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010101,
        24'hFF0001, 24'hFF0100, 24'h01FF00, 24'h00FF01, 24'h0100FF,
        24'h0001FF, 24'h000001, 24'h010000, 24'h7FFF80, 24'h123456,
        24'hFEFFFF
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #500_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Beat monitor: samples both channels at the edge, before any of this
    // edge's updates land. The input is noted before the output is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
                sb.note_pixel(pix_ch.color_word);
            if (hsv_ch.valid && hsv_ch.ready)
                sb.check_result('{hue: hsv_ch.hue_degrees,
                                  sat: hsv_ch.saturation_q16,
                                  val: hsv_ch.brightness});
        end
    end

    // Output side: random stall bursts, one long hold on request, and
    // steady ready during the final stretch.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        hsv_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                hold_left = LONG_HOLD;
                long_hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hsv_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (no_idle)
                hsv_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                hsv_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                hsv_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 9) - 1;
            end
            else
                hsv_ch.ready <= 1'b1;
        end
    end

    // Random pixel biased toward the interesting corners of the conversion.
    function automatic logic [COLOR_W-1:0] random_pixel();
        logic [CH_W-1:0] hi, lo, base;
        logic [CH_W-1:0] ext [4];
        ext  = '{8'h00, 8'h01, 8'hFE, 8'hFF};
        hi   = CH_W'($urandom_range(1, 255));
        lo   = CH_W'($urandom_range(0, hi - 1));
        base = CH_W'($urandom_range(0, 253));
        case ($urandom_range(0, 9))
            5: return {3{hi}};                                  // gray
            6: case ($urandom_range(0, 2))                      // tie for max
                   0: return {hi, hi, lo};
                   1: return {hi, lo, hi};
                   default: return {lo, hi, hi};
               endcase
            7: return {base + CH_W'($urandom_range(0, 2)),      // tiny spread
                       base + CH_W'($urandom_range(0, 2)),
                       base + CH_W'($urandom_range(0, 2))};
            8: return {ext[2'($urandom_range(0, 3))], ext[2'($urandom_range(0, 3))],
                       ext[2'($urandom_range(0, 3))]};
            9: case ($urandom_range(0, 2))                      // saturated
                   0: return {8'hFF, CH_W'($urandom), CH_W'($urandom)};
                   1: return {CH_W'($urandom), 8'hFF, CH_W'($urandom)};
                   default: return {CH_W'($urandom), CH_W'($urandom), 8'hFF};
               endcase
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Offer one pixel and hold it until taken; optionally idle afterward.
    task automatic send_pixel(input logic [COLOR_W-1:0] word, input bit may_idle);
        pix_ch.valid      <= 1'b1;
        pix_ch.color_word <= word;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        if (may_idle && !no_idle && $urandom_range(0, 4) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.color_word  <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, with idling on both sides
        foreach (CORNER_PIXELS[k])
            send_pixel(CORNER_PIXELS[k], 1'b1);
        drain();

        // random pixels with random gaps
        repeat (500)
            send_pixel(random_pixel(), 1'b1);

        // sender pauses until the block is empty
        drain();

        // output held off while the input keeps offering back to back:
        // the pipeline fills and the input must stall without losing a beat
        long_hold_pending = 1'b1;
        repeat (60)
            send_pixel(random_pixel(), 1'b0);

        repeat (500)
            send_pixel(random_pixel(), 1'b1);

        // full-rate stretch at the end
        no_idle = 1'b1;
        repeat (200)
            send_pixel(random_pixel(), 1'b0);

        drain();
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
